FILE: hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master sub-address transfer package
// Types and constants shared by the transfer controller, its register port,
// the top level and the checker.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [7:0] MSB_MASK      = 8'h80;
    localparam logic [7:0] TICKS_RESET   = 8'd5;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [2:0] STATUS_OK = 3'd0;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_ST_A  = 5'd1,
        PH_ST_B  = 5'd2,
        PH_ST_C  = 5'd3,
        PH_TX_LO = 5'd4,
        PH_TX_HI = 5'd5,
        PH_AK_LO = 5'd6,
        PH_AK_HI = 5'd7,
        PH_WAIT  = 5'd8,
        PH_RX_LO = 5'd9,
        PH_RX_HI = 5'd10,
        PH_MA_LO = 5'd11,
        PH_MA_HI = 5'd12,
        PH_RS_A  = 5'd13,
        PH_SP_A  = 5'd14,
        PH_SP_B  = 5'd15,
        PH_SP_C  = 5'd16
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_ADDR = 2'd0,
        ROLE_SUB  = 2'd1,
        ROLE_RADR = 2'd2,
        ROLE_DATA = 2'd3
    } t_role;

    typedef struct packed {
        logic [1:0] kind;
        logic       op;
        logic [7:0] device_address;
        logic [7:0] sub_address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_sample;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       need_data;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
    } t_out_item;

endpackage

FILE: hdl/i2cms_regs.sv
// ----------------------------------------------------------------------------
// I2C master register port
// APB-style slave holding the phase length register.
// ----------------------------------------------------------------------------
module i2cms_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_phase_ticks
);
    import i2cms_pkg::*;

    logic [7:0] r_phase_ticks;
    logic       w_sel_ticks;

    assign w_sel_ticks = (paddr[2] == 1'b0);
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= TICKS_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_ticks) begin
            r_phase_ticks <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (w_sel_ticks) begin
            prdata = {24'd0, r_phase_ticks};
        end
    end

    assign o_phase_ticks = r_phase_ticks;

endmodule

FILE: hdl/i2cms_core.sv
// ----------------------------------------------------------------------------
// I2C master transfer controller
// Bus phase state machine; advances by one item per step and gives that
// item's result combinationally.
// ----------------------------------------------------------------------------
module i2cms_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  i2cms_pkg::t_in_item  i_item,
    input  logic [7:0]           i_phase_ticks,
    output i2cms_pkg::t_out_item o_result
);
    import i2cms_pkg::*;

    t_phase     r_phase, n_phase;
    t_role      r_role, n_role;
    logic [7:0] r_timer, n_timer;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_bytes, n_bytes;
    logic [7:0] r_dev, n_dev;
    logic [7:0] r_sub, n_sub;
    logic       r_read_mode, n_read_mode;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [2:0] r_err, n_err;

    logic       w_enter;
    logic       w_valid;
    logic       w_done;
    logic [7:0] w_rdata;
    logic [7:0] w_limit;

    assign w_limit = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;

    always_comb begin
        n_phase     = r_phase;
        n_role      = r_role;
        n_timer     = r_timer;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_bytes     = r_bytes;
        n_dev       = r_dev;
        n_sub       = r_sub;
        n_read_mode = r_read_mode;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_err       = r_err;
        w_enter     = 1'b0;
        w_valid     = 1'b0;
        w_done      = 1'b0;
        w_rdata     = 8'd0;

        unique case (i_item.kind)
            KIND_CMD: begin
                if (r_phase == PH_IDLE) begin
                    n_read_mode = i_item.op;
                    n_dev       = i_item.device_address;
                    n_sub       = i_item.sub_address;
                    n_bytes     = i_item.byte_count;
                    if (i_item.op && (i_item.byte_count == 8'd0)) begin
                        n_bytes = 8'd1;
                    end
                    n_err   = STATUS_OK;
                    n_role  = ROLE_ADDR;
                    n_bit   = 4'd0;
                    n_shift = 8'd0;
                    n_phase = PH_ST_A;
                    w_enter = 1'b1;
                end
            end
            KIND_DATA: begin
                if (r_phase == PH_WAIT) begin
                    n_shift = i_item.write_data;
                    n_bit   = 4'd0;
                    n_phase = PH_TX_LO;
                    w_enter = 1'b1;
                end
            end
            KIND_TICK: begin
                if ((r_phase != PH_IDLE) && (r_phase != PH_WAIT)) begin
                    n_timer = r_timer + 8'd1;
                    if (n_timer >= w_limit) begin
                        w_enter = 1'b1;
                        unique case (r_phase)
                            PH_ST_A: n_phase = PH_ST_B;
                            PH_ST_B: n_phase = PH_ST_C;
                            PH_ST_C: begin
                                n_shift = (r_role == ROLE_RADR) ? r_dev + 8'd1 : r_dev;
                                n_bit   = 4'd0;
                                n_phase = PH_TX_LO;
                            end
                            PH_TX_LO: n_phase = PH_TX_HI;
                            PH_TX_HI: begin
                                n_shift = {r_shift[6:0], 1'b0};
                                n_bit   = r_bit + 4'd1;
                                n_phase = (n_bit >= BITS_PER_BYTE) ? PH_AK_LO : PH_TX_LO;
                            end
                            PH_AK_LO: n_phase = PH_AK_HI;
                            PH_AK_HI: begin
                                if (i_item.sda_sample) begin
                                    n_err   = {1'b0, r_role} + 3'd1;
                                    n_phase = PH_SP_A;
                                end else begin
                                    unique case (r_role)
                                        ROLE_ADDR: begin
                                            n_role  = ROLE_SUB;
                                            n_shift = r_sub;
                                            n_bit   = 4'd0;
                                            n_phase = PH_TX_LO;
                                        end
                                        ROLE_SUB: begin
                                            if (r_read_mode) begin
                                                n_role  = ROLE_RADR;
                                                n_phase = PH_RS_A;
                                            end else begin
                                                n_role  = ROLE_DATA;
                                                n_phase = (r_bytes == 8'd0) ? PH_SP_A
                                                                            : PH_WAIT;
                                            end
                                        end
                                        ROLE_RADR: begin
                                            n_shift = 8'd0;
                                            n_bit   = 4'd0;
                                            n_phase = PH_RX_LO;
                                        end
                                        default: begin
                                            if (r_bytes != 8'd0) begin
                                                n_bytes = r_bytes - 8'd1;
                                            end
                                            n_phase = (n_bytes == 8'd0) ? PH_SP_A : PH_WAIT;
                                        end
                                    endcase
                                end
                            end
                            PH_RX_LO: n_phase = PH_RX_HI;
                            PH_RX_HI: begin
                                n_shift = {r_shift[6:0], i_item.sda_sample};
                                n_bit   = r_bit + 4'd1;
                                if (n_bit >= BITS_PER_BYTE) begin
                                    w_valid = 1'b1;
                                    w_rdata = n_shift;
                                    n_phase = PH_MA_LO;
                                end else begin
                                    n_phase = PH_RX_LO;
                                end
                            end
                            PH_MA_LO: n_phase = PH_MA_HI;
                            PH_MA_HI: begin
                                if (r_bytes != 8'd0) begin
                                    n_bytes = r_bytes - 8'd1;
                                end
                                if (n_bytes == 8'd0) begin
                                    n_phase = PH_SP_A;
                                end else begin
                                    n_shift = 8'd0;
                                    n_bit   = 4'd0;
                                    n_phase = PH_RX_LO;
                                end
                            end
                            PH_RS_A: n_phase = PH_ST_A;
                            PH_SP_A: n_phase = PH_SP_B;
                            PH_SP_B: n_phase = PH_SP_C;
                            PH_SP_C: begin
                                n_phase = PH_IDLE;
                                w_done  = 1'b1;
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_enter) begin
            n_timer = 8'd0;
            unique case (n_phase)
                PH_ST_A:  begin n_scl = 1'b1; n_sda = 1'b1; end
                PH_ST_B:  begin n_scl = 1'b1; n_sda = 1'b0; end
                PH_ST_C:  begin n_scl = 1'b0; n_sda = 1'b0; end
                PH_TX_LO: begin n_scl = 1'b0; n_sda = ((n_shift & MSB_MASK) != 8'd0); end
                PH_TX_HI: n_scl = 1'b1;
                PH_AK_LO: begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_AK_HI: n_scl = 1'b1;
                PH_WAIT:  n_scl = 1'b0;
                PH_RX_LO: begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_RX_HI: n_scl = 1'b1;
                PH_MA_LO: begin n_scl = 1'b0; n_sda = (n_bytes > 8'd1) ? 1'b0 : 1'b1; end
                PH_MA_HI: n_scl = 1'b1;
                PH_RS_A:  begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_SP_A:  begin n_scl = 1'b0; n_sda = 1'b0; end
                PH_SP_B:  n_scl = 1'b1;
                PH_SP_C:  begin n_scl = 1'b1; n_sda = 1'b1; end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_role      <= ROLE_ADDR;
            r_timer     <= 8'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_bytes     <= 8'd0;
            r_dev       <= 8'd0;
            r_sub       <= 8'd0;
            r_read_mode <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_err       <= STATUS_OK;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_role      <= n_role;
            r_timer     <= n_timer;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_bytes     <= n_bytes;
            r_dev       <= n_dev;
            r_sub       <= n_sub;
            r_read_mode <= n_read_mode;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_err       <= n_err;
        end
    end

    always_comb begin
        o_result.scl_out    = n_scl;
        o_result.sda_out    = n_sda;
        o_result.read_data  = w_rdata;
        o_result.read_valid = w_valid;
        o_result.need_data  = (n_phase == PH_WAIT);
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = w_done;
        o_result.status     = n_err;
    end

endmodule

FILE: hdl/i2c_master_subaddress_transfer.sv
// ----------------------------------------------------------------------------
// I2C master sub-address transfer
// Runs a complete sub-addressed register write or read on an I2C bus,
// stepped by tick items, with one result item for every input item.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_stall  o_out_item (t_out_item)
//   config    input      APB psel / penable         phase_ticks at address 0
//
// An item is taken into the input register, stepped through the phase state
// machine and its result registered in the output register; one item is
// accepted every cycle while the output is not stalled.
// Synchronous reset returns the bus to released with the controller idle.
// A stall on the output holds the result register and a full input register.
// ----------------------------------------------------------------------------
module i2c_master_subaddress_transfer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  i2cms_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output i2cms_pkg::t_out_item o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import i2cms_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic       w_out_free;
    logic       w_step;
    logic [7:0] w_phase_ticks;
    t_out_item  w_result;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    i2cms_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_phase_ticks (w_phase_ticks)
    );

    i2cms_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_item        (r_in_item),
        .i_phase_ticks (w_phase_ticks),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hdl/i2cms_checker.sv
// ----------------------------------------------------------------------------
// I2C master port checker
// Concurrent checks on the ports of the transfer top level, bound to it.
// ----------------------------------------------------------------------------
module i2cms_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input i2cms_pkg::t_out_item o_out_item,
    input logic                 pready
);
    import i2cms_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("Result item changed while stalled.");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.read_valid |-> o_out_item.busy_res && !o_out_item.done_res)
        else $error("Received byte reported outside a transfer.");

    a_done_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |->
            !o_out_item.busy_res && o_out_item.scl_out && o_out_item.sda_out)
        else $error("Transfer finished without releasing the bus.");

    a_wait_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.need_data |-> o_out_item.busy_res && !o_out_item.scl_out)
        else $error("Waiting for a write byte without holding SCL low.");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("Register port not ready.");

endmodule

bind i2c_master_subaddress_transfer i2cms_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .pready      (pready)
);
